### sv/mfde_pkg.sv
package mfde_pkg;

  typedef enum logic [2:0] {
    CMD_FILL   = 3'd0,
    CMD_PIXEL  = 3'd1,
    CMD_HLINE  = 3'd2,
    CMD_VLINE  = 3'd3,
    CMD_RECT   = 3'd4,
    CMD_CURSOR = 3'd5,
    CMD_CHAR   = 3'd6,
    CMD_READ   = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_PIX,
    ST_WR,
    ST_RD,
    ST_RDW
  } back_state_t;

  // one queued command
  typedef struct packed {
    cmd_t              cmd;
    logic signed [9:0] x_pos;
    logic signed [9:0] y_pos;
    logic [8:0]        span_w;
    logic [8:0]        span_h;
    logic              pixel_on;
    logic [7:0]        char_code;
    logic [9:0]        byte_addr;
  } item_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  // back end status toward the front end
  typedef struct packed {
    logic clearing;
    logic pop;
  } back_status_t;

  localparam int COORD_W     = 12;
  localparam int STORE_BYTES = 1024;
  localparam int ADDR_W      = 10;
  localparam int CELL_STEP   = 6;
  localparam int ROW_STEP    = 8;
  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_ROWS  = 7;
  localparam int LOWER_SHIFT = 32;

  // 5x7 font: column 0 in the lowest byte, bit n of a byte is row n
  function automatic logic [39:0] glyph_bits(input logic [7:0] code);
    logic [7:0]  c;
    logic [39:0] g;
    c = code;
    if (code >= 8'h61 && code <= 8'h7A) begin
      c = code - 8'(LOWER_SHIFT);
    end
    unique case (c)
      8'h30: g = {8'h3E, 8'h45, 8'h49, 8'h51, 8'h3E};
      8'h31: g = {8'h00, 8'h40, 8'h7F, 8'h42, 8'h00};
      8'h32: g = {8'h46, 8'h49, 8'h51, 8'h61, 8'h42};
      8'h33: g = {8'h31, 8'h4B, 8'h45, 8'h41, 8'h21};
      8'h34: g = {8'h10, 8'h7F, 8'h12, 8'h14, 8'h18};
      8'h35: g = {8'h39, 8'h45, 8'h45, 8'h45, 8'h27};
      8'h36: g = {8'h30, 8'h49, 8'h49, 8'h4A, 8'h3C};
      8'h37: g = {8'h03, 8'h05, 8'h09, 8'h71, 8'h01};
      8'h38: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
      8'h39: g = {8'h1E, 8'h29, 8'h49, 8'h49, 8'h06};
      8'h41: g = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
      8'h42: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h7F};
      8'h43: g = {8'h22, 8'h41, 8'h41, 8'h41, 8'h3E};
      8'h44: g = {8'h1C, 8'h22, 8'h41, 8'h41, 8'h7F};
      8'h45: g = {8'h41, 8'h49, 8'h49, 8'h49, 8'h7F};
      8'h46: g = {8'h01, 8'h09, 8'h09, 8'h09, 8'h7F};
      8'h47: g = {8'h7A, 8'h49, 8'h49, 8'h41, 8'h3E};
      8'h48: g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
      8'h49: g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
      8'h4A: g = {8'h01, 8'h3F, 8'h41, 8'h40, 8'h20};
      8'h4B: g = {8'h41, 8'h22, 8'h14, 8'h08, 8'h7F};
      8'h4C: g = {8'h40, 8'h40, 8'h40, 8'h40, 8'h7F};
      8'h4D: g = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
      8'h4E: g = {8'h7F, 8'h10, 8'h08, 8'h04, 8'h7F};
      8'h4F: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
      8'h50: g = {8'h06, 8'h09, 8'h09, 8'h09, 8'h7F};
      8'h51: g = {8'h5E, 8'h21, 8'h51, 8'h41, 8'h3E};
      8'h52: g = {8'h46, 8'h29, 8'h19, 8'h09, 8'h7F};
      8'h53: g = {8'h31, 8'h49, 8'h49, 8'h49, 8'h46};
      8'h54: g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
      8'h55: g = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
      8'h56: g = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
      8'h57: g = {8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F};
      8'h58: g = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
      8'h59: g = {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
      8'h5A: g = {8'h43, 8'h45, 8'h49, 8'h51, 8'h61};
      8'h3A: g = {8'h00, 8'h00, 8'h36, 8'h36, 8'h00};
      8'h2D: g = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
      8'h3E: g = {8'h00, 8'h08, 8'h14, 8'h22, 8'h41};
      8'h2F: g = {8'h02, 8'h04, 8'h08, 8'h10, 8'h20};
      8'h2E: g = {8'h00, 8'h00, 8'h60, 8'h60, 8'h00};
      8'h25: g = {8'h63, 8'h64, 8'h08, 8'h13, 8'h63};
      default: g = 40'h0;
    endcase
    return g;
  endfunction

endpackage

### sv/mfde_front.sv
module mfde_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [63:0]             in_tdata,
  input  logic [2:0]              in_tuser,
  input  mfde_pkg::back_status_t  status,
  output mfde_pkg::queue_head_t   head
);

  localparam int DEPTH = 4;
  localparam int PTR_W = 2;

  mfde_pkg::item_t queue_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;
  mfde_pkg::item_t  item;
  logic             push;

  // unpack the beat into a command
  always_comb begin
    item.cmd       = mfde_pkg::cmd_t'(in_tuser);
    item.x_pos     = in_tdata[9:0];
    item.y_pos     = in_tdata[19:10];
    item.span_w    = in_tdata[28:20];
    item.span_h    = in_tdata[37:29];
    item.pixel_on  = in_tdata[38];
    item.char_code = in_tdata[46:39];
    item.byte_addr = in_tdata[56:47];
  end

  // hold off input while the queue is full or the store is swept after reset
  assign in_tready = (count_r != (PTR_W+1)'(DEPTH)) && !status.clearing;
  assign push      = in_tvalid && in_tready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(status.pop);
    count_nxt  = count_r + (PTR_W+1)'(push) - (PTR_W+1)'(status.pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= item;
    end
  end

  assign head.valid = (count_r != '0);
  assign head.item  = queue_r[rd_ptr_r];

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    status.clearing |-> !in_tready) else $error("beat taken during clear");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    status.pop |-> count_r != '0) else $error("pop from empty queue");

endmodule

### sv/mfde_back.sv
module mfde_back #(
  parameter int SCREEN_W = 128,
  parameter int SCREEN_H = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mfde_pkg::queue_head_t   head,
  output mfde_pkg::back_status_t  status,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [23:0]             out_tdata
);

  localparam int CW    = mfde_pkg::COORD_W;
  localparam int AW    = mfde_pkg::ADDR_W;
  localparam int IDX_W = 14;
  localparam int WRAP  = SCREEN_W - mfde_pkg::CELL_STEP;

  mfde_pkg::back_state_t state_r, state_nxt;
  mfde_pkg::item_t       it_r, it_nxt;

  logic [7:0]           mem_r [mfde_pkg::STORE_BYTES];
  logic [7:0]           rd_q;
  logic [AW-1:0]        ra, wa;
  logic [7:0]           wd;
  logic                 we;

  logic [AW-1:0]        cnt_r, cnt_nxt;
  logic                 clr_val_r, clr_val_nxt;
  logic [2:0]           seg_r, seg_nxt;
  logic [39:0]          glyph_r, glyph_nxt;
  logic signed [CW-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic [8:0]           len_r, len_nxt, i_r, i_nxt;
  logic                 vert_r, vert_nxt;
  logic [AW-1:0]        pend_idx_r, pend_idx_nxt;
  logic [2:0]           pend_bit_r, pend_bit_nxt;
  logic                 pend_on_r, pend_on_nxt;
  logic [7:0]           col_r, col_nxt, row_r, row_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [23:0]          out_data_r, out_data_nxt;
  logic                 pop;

  logic signed [CW-1:0] xe, ye, we_ext, he_ext;
  logic signed [CW-1:0] px, py;
  logic [IDX_W-1:0]     pix_idx;
  logic                 skip;
  logic [2:0]           last_seg;
  logic [7:0]           gcol;
  logic                 pix_on;
  logic [7:0]           col_sum;

  // operands of the current command, widened
  always_comb begin
    xe     = CW'(it_r.x_pos);
    ye     = CW'(it_r.y_pos);
    we_ext = CW'(signed'({1'b0, it_r.span_w}));
    he_ext = CW'(signed'({1'b0, it_r.span_h}));
  end

  // current pixel of the segment
  always_comb begin
    px      = sx_r + (vert_r ? CW'(0) : CW'(signed'({1'b0, i_r})));
    py      = sy_r + (vert_r ? CW'(signed'({1'b0, i_r})) : CW'(0));
    pix_idx = IDX_W'(px[7:0]) + IDX_W'(py[7:3]) * IDX_W'(SCREEN_W);
    skip    = px[CW-1] || py[CW-1] || (px >= CW'(SCREEN_W)) || (py >= CW'(SCREEN_H))
              || (pix_idx >= IDX_W'(mfde_pkg::STORE_BYTES));
    unique case (seg_r)
      3'd0:    gcol = glyph_r[7:0];
      3'd1:    gcol = glyph_r[15:8];
      3'd2:    gcol = glyph_r[23:16];
      3'd3:    gcol = glyph_r[31:24];
      default: gcol = glyph_r[39:32];
    endcase
    pix_on = (it_r.cmd == mfde_pkg::CMD_CHAR) ? gcol[i_r[2:0]] : it_r.pixel_on;
    priority case (it_r.cmd)
      mfde_pkg::CMD_RECT: last_seg = 3'd3;
      mfde_pkg::CMD_CHAR: last_seg = 3'(mfde_pkg::GLYPH_COLS - 1);
      default:            last_seg = 3'd0;
    endcase
    col_sum = col_r + 8'(mfde_pkg::CELL_STEP);
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    it_nxt        = it_r;
    cnt_nxt       = cnt_r;
    clr_val_nxt   = clr_val_r;
    seg_nxt       = seg_r;
    glyph_nxt     = glyph_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    len_nxt       = len_r;
    vert_nxt      = vert_r;
    i_nxt         = i_r;
    pend_idx_nxt  = pend_idx_r;
    pend_bit_nxt  = pend_bit_r;
    pend_on_nxt   = pend_on_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;
    we            = 1'b0;
    wa            = pend_idx_r;
    wd            = 8'h00;
    ra            = pix_idx[AW-1:0];
    unique case (state_r)
      mfde_pkg::ST_CLEAR: begin
        we = 1'b1;
        wa = cnt_r;
        wd = {8{clr_val_r}};
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == AW'(mfde_pkg::STORE_BYTES - 1)) begin
          state_nxt = mfde_pkg::ST_IDLE;
        end
      end
      mfde_pkg::ST_IDLE: begin
        if (head.valid) begin
          pop       = 1'b1;
          it_nxt    = head.item;
          seg_nxt   = 3'd0;
          glyph_nxt = mfde_pkg::glyph_bits(head.item.char_code);
          unique case (head.item.cmd)
            mfde_pkg::CMD_FILL: begin
              clr_val_nxt = head.item.pixel_on;
              cnt_nxt     = '0;
              state_nxt   = mfde_pkg::ST_CLEAR;
            end
            mfde_pkg::CMD_CURSOR: begin
              col_nxt = head.item.x_pos[7:0];
              row_nxt = head.item.y_pos[7:0];
            end
            mfde_pkg::CMD_READ: state_nxt = mfde_pkg::ST_RD;
            default:            state_nxt = mfde_pkg::ST_LOAD;
          endcase
        end
      end
      mfde_pkg::ST_LOAD: begin
        // set up one straight run of pixels
        i_nxt     = '0;
        sx_nxt    = xe;
        sy_nxt    = ye;
        vert_nxt  = 1'b0;
        len_nxt   = it_r.span_w;
        state_nxt = mfde_pkg::ST_PIX;
        unique case (it_r.cmd)
          mfde_pkg::CMD_PIXEL: len_nxt = 9'd1;
          mfde_pkg::CMD_VLINE: begin
            vert_nxt = 1'b1;
            len_nxt  = it_r.span_h;
          end
          mfde_pkg::CMD_RECT: begin
            unique case (seg_r)
              3'd1:    sy_nxt = ye + he_ext - CW'(1);
              3'd2: begin
                vert_nxt = 1'b1;
                len_nxt  = it_r.span_h;
              end
              3'd3: begin
                sx_nxt   = xe + we_ext - CW'(1);
                vert_nxt = 1'b1;
                len_nxt  = it_r.span_h;
              end
              default: ;
            endcase
          end
          mfde_pkg::CMD_CHAR: begin
            sx_nxt   = CW'(col_r) + CW'(seg_r);
            sy_nxt   = CW'(row_r);
            vert_nxt = 1'b1;
            len_nxt  = 9'(mfde_pkg::GLYPH_ROWS);
          end
          default: ;
        endcase
      end
      mfde_pkg::ST_PIX: begin
        if (i_r == len_r) begin
          if (seg_r == last_seg) begin
            state_nxt = mfde_pkg::ST_IDLE;
            if (it_r.cmd == mfde_pkg::CMD_CHAR) begin
              // advance the cursor, wrap to the next text line
              if ({1'b0, col_sum} > 9'(WRAP)) begin
                col_nxt = 8'h00;
                row_nxt = row_r + 8'(mfde_pkg::ROW_STEP);
              end else begin
                col_nxt = col_sum;
              end
            end
          end else begin
            seg_nxt   = seg_r + 3'd1;
            state_nxt = mfde_pkg::ST_LOAD;
          end
        end else if (skip) begin
          i_nxt = i_r + 9'd1;
        end else begin
          pend_idx_nxt = pix_idx[AW-1:0];
          pend_bit_nxt = py[2:0];
          pend_on_nxt  = pix_on;
          state_nxt    = mfde_pkg::ST_WR;
        end
      end
      mfde_pkg::ST_WR: begin
        // merge the pixel into the byte read last cycle
        we = 1'b1;
        wd = pend_on_r ? (rd_q | (8'h01 << pend_bit_r)) : (rd_q & ~(8'h01 << pend_bit_r));
        i_nxt     = i_r + 9'd1;
        state_nxt = mfde_pkg::ST_PIX;
      end
      mfde_pkg::ST_RD: begin
        ra        = it_r.byte_addr;
        state_nxt = mfde_pkg::ST_RDW;
      end
      mfde_pkg::ST_RDW: begin
        ra = it_r.byte_addr;
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {row_r, col_r, rd_q};
          state_nxt     = mfde_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mfde_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mfde_pkg::ST_CLEAR;
      it_r        <= '{cmd: mfde_pkg::CMD_READ, default: '0};
      cnt_r       <= '0;
      clr_val_r   <= 1'b0;
      col_r       <= 8'h00;
      row_r       <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      it_r        <= it_nxt;
      cnt_r       <= cnt_nxt;
      clr_val_r   <= clr_val_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seg_r      <= seg_nxt;
    glyph_r    <= glyph_nxt;
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    len_r      <= len_nxt;
    vert_r     <= vert_nxt;
    i_r        <= i_nxt;
    pend_idx_r <= pend_idx_nxt;
    pend_bit_r <= pend_bit_nxt;
    pend_on_r  <= pend_on_nxt;
    out_data_r <= out_data_nxt;
  end

  // frame store
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wa] <= wd;
    end
    rd_q <= mem_r[ra];
  end

  assign status.clearing = (state_r == mfde_pkg::ST_CLEAR) && (it_r.cmd != mfde_pkg::CMD_FILL
                           || !rst_n);
  assign status.pop      = pop;
  assign out_tvalid      = out_valid_r;
  assign out_tdata       = out_data_r;

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == mfde_pkg::ST_WR || state_r == mfde_pkg::ST_CLEAR))
    else $error("store written outside write states");
  a_wr_returns: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mfde_pkg::ST_WR |=> state_r == mfde_pkg::ST_PIX)
    else $error("write not followed by next pixel");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> state_r == mfde_pkg::ST_IDLE) else $error("pop while busy");

endmodule

### sv/mono_framebuffer_draw_engine_core.sv
// Monochrome page-mode frame-store drawing engine.
// Input channel in_*: one beat is one drawing command, selected by in_tuser.
// A four-entry command queue decouples the input from the draw sequencer, so
// beats are taken while a command is still being drawn.
// Output channel out_*: one beat per read-byte command, nothing for others.
// Sequencer steps: each command leaves the queue in the idle state; each drawn
// pixel is read and then written back (states PIX and WR, a read-modify-write
// of its store byte), a clipped pixel is skipped in PIX, each straight run has a
// setup state (LOAD) and closes in PIX; a character is five vertical runs of
// seven pixels, a rectangle 2*(w+h) pixels, fill one byte per cycle, a read
// byte passes RD and RDW to the output register; set cursor is done in idle.
// Reset: synchronous, active low; afterwards the store is swept to zero, during
// which in_tready stays low. Cursor resets to (0,0).
// Stall: a result waits in the output register while out_tready is low; a later
// read then holds the sequencer in its read state and the queue fills until full.
module mono_framebuffer_draw_engine_core #(
  parameter int SCREEN_W = 128,
  parameter int SCREEN_H = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // x_pos[9:0], y_pos[19:10], span_w[28:20], span_h[37:29], pixel_on[38],
  // char_code[46:39], byte_addr[56:47], zero fill above
  input  logic [63:0] in_tdata,
  // cmd[2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_byte[7:0], cursor_col_out[15:8], cursor_row_out[23:16]
  output logic [23:0] out_tdata
);

  mfde_pkg::queue_head_t  head;
  mfde_pkg::back_status_t status;

  mfde_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .status    (status),
    .head      (head)
  );

  mfde_back #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
